// ===== rtl/core/wis_pkg.sv =====
package wis_pkg;

    localparam int unsigned LEAVES_DEFAULT      = 16;
    localparam int unsigned WEIGHT_BITS_DEFAULT = 16;

    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned WGT_W   = 16;
    localparam int unsigned DRAW_W  = 20;
    localparam int unsigned TOTAL_W = 20;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PICK = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DESCEND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0]  picked_index;
        logic               out_of_range;
        logic [TOTAL_W-1:0] total_weight;
    } t_result;

endpackage

// ===== rtl/core/weighted_index_sampler_top.sv =====
// weighted index sampler: sum tree over LEAVES weight slots kept in one ram
// input channel (i_valid/o_ready) takes one item per beat: i_operation selects
// a load (replace the weight of i_slot_index) or a pick (descend the tree with
// draw i_random_value). output channel (o_valid/i_ready) returns one result
// beat per item: picked slot, out-of-range flag and the total weight.
// the tree has L = clog2(LEAVES) levels below the root; every level costs one
// ram access; on a load each node is read and written back in the next cycle.
// load: the accept step, update steps walking leaf to root, then the result
// step; the next item is accepted only once the sequencer is idle again.
// pick: the accept step, descent steps walking root to leaf, then the result step.
// ignored loads and out-of-range draws skip the tree walk and go straight to the result step.
// the result sits in an output register, so a stalled receiver holds it while
// the next item is already accepted.
// at reset a clearing pass writes zero to all 2*2^L ram entries (32 for 16
// slots); no item is accepted until it ends.
// a result still held when its successor finishes stalls the sequencer.
module weighted_index_sampler_top #(
    parameter int unsigned LEAVES      = wis_pkg::LEAVES_DEFAULT,
    parameter int unsigned WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_operation,
    input  logic [wis_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [wis_pkg::WGT_W-1:0]    i_weight_value,
    input  logic [wis_pkg::DRAW_W-1:0]   i_random_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wis_pkg::SLOT_W-1:0]   o_picked_index,
    output logic                         o_out_of_range,
    output logic [wis_pkg::TOTAL_W-1:0]  o_total_weight
);

    import wis_pkg::*;

    localparam int unsigned LVL   = $clog2(LEAVES);
    localparam int unsigned AW    = LVL + 1;
    localparam int unsigned DEPTH = 2 * (1 << LVL);
    localparam int unsigned WB_EF = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
    localparam int unsigned SUM_W = WB_EF + LVL;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [SUM_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [SUM_W-1:0] w_rdata;
    logic             w_push;
    logic             w_free;
    t_result          w_result;
    t_result          w_out;

    wis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wis_seq #(
        .LEAVES      (LEAVES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_slot_index   (i_slot_index),
        .i_weight_value (i_weight_value),
        .i_random_value (i_random_value),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_push         (w_push),
        .o_result       (w_result),
        .i_free         (w_free)
    );

    wis_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_free   (w_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_out)
    );

    assign o_picked_index = w_out.picked_index;
    assign o_out_of_range = w_out.out_of_range;
    assign o_total_weight = w_out.total_weight;

endmodule

// ===== rtl/core/wis_ram.sv =====
module wis_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/wis_out.sv =====
module wis_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wis_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output wis_pkg::t_result o_result
);

    import wis_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/wis_seq.sv =====
module wis_seq #(
    parameter int unsigned LEAVES      = wis_pkg::LEAVES_DEFAULT,
    parameter int unsigned WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEFAULT,
    localparam int unsigned LVL   = $clog2(LEAVES),
    localparam int unsigned AW    = LVL + 1,
    localparam int unsigned WB_EF = (WEIGHT_BITS < wis_pkg::WGT_W) ? WEIGHT_BITS
                                                                   : wis_pkg::WGT_W,
    localparam int unsigned SUM_W = WB_EF + LVL
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_operation,
    input  logic [wis_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [wis_pkg::WGT_W-1:0]    i_weight_value,
    input  logic [wis_pkg::DRAW_W-1:0]   i_random_value,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [SUM_W-1:0]             o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  logic [SUM_W-1:0]             i_rdata,
    output logic                         o_push,
    output wis_pkg::t_result             o_result,
    input  logic                         i_free
);

    import wis_pkg::*;

    localparam int unsigned P     = 1 << LVL;
    localparam int unsigned DEPTH = 2 * P;
    localparam int unsigned CW    = (SUM_W > DRAW_W) ? SUM_W : DRAW_W;

    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_node;
    logic [AW-1:0]       r_clr;
    logic                r_first;
    logic [SUM_W-1:0]    r_delta;
    logic [WB_EF-1:0]    r_weight;
    logic [DRAW_W-1:0]   r_draw;
    logic [SUM_W-1:0]    r_total;
    logic [SLOT_W-1:0]   r_picked;
    logic                r_oob;

    logic                w_accept;
    logic                w_slot_ok;
    logic                w_oob;
    logic [AW-1:0]       w_leaf_addr;
    logic [SUM_W-1:0]    w_delta_new;
    logic [SUM_W-1:0]    w_upd;
    logic                w_go_left;
    logic [AW-1:0]       w_next_node;
    logic [DRAW_W-1:0]   w_next_draw;
    logic [CW-1:0]       w_draw_ext;
    logic [CW-1:0]       w_total_ext;
    logic [CW-1:0]       w_lsum_ext;
    logic [CW-1:0]       w_cur_draw_ext;

    assign w_accept    = i_valid && o_ready;
    assign w_slot_ok   = 32'(i_slot_index) < LEAVES;
    assign w_leaf_addr = AW'(P) + AW'(i_slot_index);
    assign w_draw_ext  = CW'(i_random_value);
    assign w_total_ext = CW'(r_total);
    assign w_oob       = (w_draw_ext == '0) || (w_draw_ext > w_total_ext);

    // path update: first beat writes the leaf, the rest add the delta
    assign w_delta_new = SUM_W'(r_weight) - i_rdata;
    assign w_upd       = r_first ? SUM_W'(r_weight) : (i_rdata + r_delta);

    // descent: compare draw against left child sum
    assign w_lsum_ext     = CW'(i_rdata);
    assign w_cur_draw_ext = CW'(r_draw);
    assign w_go_left      = w_cur_draw_ext <= w_lsum_ext;
    assign w_next_node    = {r_node[AW-2:0], !w_go_left};
    assign w_next_draw    = w_go_left ? r_draw
                                      : DRAW_W'(w_cur_draw_ext - w_lsum_ext);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_LOAD) begin
                        n_state = w_slot_ok ? ST_UPDATE : ST_DONE;
                    end else begin
                        n_state = w_oob ? ST_DONE : ST_DESCEND;
                    end
                end
            end
            ST_UPDATE: begin
                if (r_node == AW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DESCEND: begin
                if (w_next_node[LVL]) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_node;
        o_wdata = w_upd;
        o_raddr = '0;
        o_push  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                o_raddr = (i_operation == OP_LOAD) ? w_leaf_addr : AW'(2);
            end
            ST_UPDATE: begin
                o_we    = 1'b1;
                o_raddr = r_node >> 1;
            end
            ST_DESCEND: begin
                o_raddr = {w_next_node[AW-2:0], 1'b0};
            end
            ST_DONE: begin
                o_push = i_free;
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_total <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                end
                ST_IDLE: begin
                    r_first <= 1'b1;
                end
                ST_UPDATE: begin
                    r_first <= 1'b0;
                    if (r_node == AW'(1)) begin
                        r_total <= w_upd;
                    end
                end
                default: r_first <= r_first;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_weight <= i_weight_value[WB_EF-1:0];
                    r_draw   <= i_random_value;
                    r_node   <= (i_operation == OP_LOAD) ? w_leaf_addr : AW'(1);
                    r_picked <= '0;
                    r_oob    <= (i_operation == OP_PICK) && w_oob;
                end
            end
            ST_UPDATE: begin
                if (r_first) begin
                    r_delta <= w_delta_new;
                end
                r_node <= r_node >> 1;
            end
            ST_DESCEND: begin
                r_node <= w_next_node;
                r_draw <= w_next_draw;
                if (w_next_node[LVL]) begin
                    r_picked <= SLOT_W'(w_next_node[LVL-1:0]);
                end
            end
            default: r_node <= r_node;
        endcase
    end

    assign o_result.picked_index = r_picked;
    assign o_result.out_of_range = r_oob;
    assign o_result.total_weight = w_total_ext[TOTAL_W-1:0];

endmodule
